>>> hw/rtl/jrsf_pkg.sv
// Shared types and constants for the JPEG restart/stuffing framer.
// No dependencies; imported by every module of the framer.
package jrsf_pkg;

	typedef enum logic [1:0] {
		OP_DATA  = 2'd0,
		OP_BLOCK = 2'd1,
		OP_EOI   = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [7:0] MARK_PREFIX = 8'hFF;
	localparam logic [7:0] STUFF_BYTE  = 8'h00;
	localparam logic [7:0] RST_BASE    = 8'hD0;
	localparam logic [7:0] EOI_CODE    = 8'hD9;

	// One queued command: one or two stream bytes.
	typedef struct packed {
		logic       two;
		logic [7:0] byte0;
		logic [7:0] byte1;
	} cmd_t;

	// Front to queue: write request.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_req_t;

endpackage

>>> hw/rtl/jrsf_front.sv
// Front end: classifies input words into byte commands and keeps the frame state.
// Depends on jrsf_pkg.
module jrsf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [1:0]        operation,
	input  logic [7:0]        data_byte,
	output jrsf_pkg::cmd_req_t req
);
	import jrsf_pkg::*;

	logic [2:0] marker_index_q;
	logic       block_seen_q;
	op_t        op;

	assign op = op_t'(operation);

	always_comb begin
		req.valid     = 1'b0;
		req.cmd.two   = 1'b0;
		req.cmd.byte0 = MARK_PREFIX;
		req.cmd.byte1 = STUFF_BYTE;
		unique case (op)
			OP_DATA: begin
				req.valid     = 1'b1;
				req.cmd.byte0 = data_byte;
				req.cmd.two   = (data_byte == MARK_PREFIX);
			end
			OP_BLOCK: begin
				// first block of a frame carries no marker
				req.valid     = block_seen_q;
				req.cmd.two   = 1'b1;
				req.cmd.byte1 = RST_BASE | {5'd0, marker_index_q};
			end
			OP_EOI: begin
				req.valid     = 1'b1;
				req.cmd.two   = 1'b1;
				req.cmd.byte1 = EOI_CODE;
			end
			default: begin
				req.valid = 1'b0;
			end
		endcase
		req.valid = req.valid & accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_index_q <= 3'd0;
			block_seen_q   <= 1'b0;
		end else if (accept) begin
			unique case (op)
				OP_DATA: begin
					block_seen_q <= 1'b1;
				end
				OP_BLOCK: begin
					if (block_seen_q) begin
						marker_index_q <= marker_index_q + 3'd1;
					end
					block_seen_q <= 1'b1;
				end
				OP_EOI: begin
					marker_index_q <= 3'd0;
					block_seen_q   <= 1'b0;
				end
				default: begin
					block_seen_q <= block_seen_q;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/jrsf_cmd_fifo.sv
// Command queue between front and back end.
// Depends on jrsf_pkg.
module jrsf_cmd_fifo #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  jrsf_pkg::cmd_req_t wr,
	output logic               full,
	input  logic               rd_en,
	output jrsf_pkg::cmd_t     rd_data,
	output logic               empty
);
	import jrsf_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_wr   = wr.valid & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> hw/rtl/jrsf_back.sv
// Back end: serialises queued commands into stream bytes through an output register.
// Depends on jrsf_pkg.
module jrsf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  jrsf_pkg::cmd_t cmd,
	input  logic           cmd_empty,
	output logic           cmd_pop,
	input  logic           pop,
	output logic           empty,
	output logic [7:0]     out_byte,
	output logic           last
);
	import jrsf_pkg::*;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic       pend_valid_q;
	logic [7:0] pend_byte_q;
	logic       slot_free;
	logic       load_pend;

	assign slot_free = ~out_valid_q | pop;
	assign load_pend = slot_free & pend_valid_q;
	assign cmd_pop   = slot_free & ~pend_valid_q & ~cmd_empty;

	assign empty    = ~out_valid_q;
	assign out_byte = out_byte_q;
	assign last     = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (slot_free) begin
				out_valid_q <= pend_valid_q | ~cmd_empty;
			end
			if (load_pend) begin
				pend_valid_q <= 1'b0;
			end else if (cmd_pop) begin
				pend_valid_q <= cmd.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_pend) begin
			out_byte_q <= pend_byte_q;
			last_q     <= 1'b1;
		end else if (cmd_pop) begin
			out_byte_q  <= cmd.byte0;
			last_q      <= ~cmd.two;
			// hold the second byte for the next slot
			pend_byte_q <= cmd.byte1;
		end
	end

endmodule

>>> hw/rtl/jpeg_restart_stuffing_framer_core.sv
// JPEG restart/stuffing framer: takes data bytes, block starts and end of frame
// and emits the entropy-coded stream with restart markers, 0xFF stuffing and EOI.
// An item is taken in the cycle push is high and full is low; it is classified
// in that cycle and, if it yields bytes, queued in a CMD_DEPTH-entry queue. The
// output side delivers one byte per cycle while pop is high, from a single
// output register; a data byte yields one byte, and a marker, a stuffed 0xFF or
// EOI yields two. full rises only when the queue holds CMD_DEPTH items not yet
// started on. Bytes pass the queue, then the output register. Depends on jrsf_pkg.
module jpeg_restart_stuffing_framer_core #(
	parameter int CMD_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] operation,
	input  logic [7:0] data_byte,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_byte,
	output logic       last
);
	import jrsf_pkg::*;

	cmd_req_t req;
	cmd_t     head;
	logic     head_empty;
	logic     head_pop;
	logic     accept;

	assign accept = push & ~full;

	jrsf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (operation),
		.data_byte (data_byte),
		.req       (req)
	);

	jrsf_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (req),
		.full    (full),
		.rd_en   (head_pop),
		.rd_data (head),
		.empty   (head_empty)
	);

	jrsf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head),
		.cmd_empty (head_empty),
		.cmd_pop   (head_pop),
		.pop       (pop),
		.empty     (empty),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule
